// ===== rtl/core/mfc_pkg.sv =====
`default_nettype none

package mfc_pkg;

  // Widths fixed by the item formats.
  localparam int SAMPLE_BITS = 16;
  localparam int TIDX_BITS   = 7;
  localparam int TAP_BITS    = 8;
  localparam int CONV_BITS   = 39;
  localparam int OIDX_BITS   = 16;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;

  localparam logic [TAP_BITS-1:0] TAP_RESET = 8'd101;

  // Request codes.
  localparam logic [1:0] REQ_TMPL   = 2'd0;
  localparam logic [1:0] REQ_SIGNAL = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [TIDX_BITS-1:0]          template_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CONV_BITS-1:0] conv_value;
    logic [OIDX_BITS-1:0]        out_index;
  } out_item_t;

  // Per-tap control that travels alongside the memory reads into the MAC.
  typedef struct packed {
    logic vld;    // a tap is issued this cycle
    logic live;   // the history entry is newer than the last clear
    logic first;  // first tap of the sum
    logic last;   // last tap of the sum
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_HOLD
  } st_t;

endpackage

`default_nettype wire

// ===== rtl/core/mfc_ram.sv =====
`default_nettype none

module mfc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mfc_mac.sv =====
`default_nettype none

module mfc_mac (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mfc_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [mfc_pkg::SAMPLE_BITS-1:0] tap_data,
  input  wire logic signed [mfc_pkg::SAMPLE_BITS-1:0] hist_data,
  output logic signed      [mfc_pkg::CONV_BITS-1:0]   acc,
  output logic                                     done
);

  import mfc_pkg::*;

  mac_ctl_t                    ctl_d1_r;
  mac_ctl_t                    ctl_d2_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [PROD_BITS-1:0] prod_nxt;
  logic signed [CONV_BITS-1:0] acc_r;
  logic signed [CONV_BITS-1:0] acc_nxt;
  logic                        done_r;

  // Entries older than the last clear count as zero.
  always_comb begin
    prod_nxt = '0;
    if (ctl_d1_r.live) begin
      prod_nxt = tap_data * hist_data;
    end
    acc_nxt  = (ctl_d2_r.first ? '0 : acc_r)
             + {{(CONV_BITS-PROD_BITS){prod_r[PROD_BITS-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      done_r   <= 1'b0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
      done_r   <= ctl_d2_r.vld && ctl_d2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_d1_r.vld) begin
      prod_r <= prod_nxt;
    end
    if (ctl_d2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/matched_filter_correlator.sv =====
`default_nettype none

// Channel | Direction | Signals                          | Transfer when
// --------+-----------+----------------------------------+--------------------------
// in      | input     | in_valid, in_ready, in_item      | in_valid && in_ready
// out     | output    | out_valid, out_ready, out_item   | out_valid && out_ready
// cfg     | input     | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//
// A template write or a clear request needs no sequencing. A signal sample or a flush
// tick runs a sum over taps, taps being tap_count with zero read as one and values
// above MAX_TAPS clipped: one tap per cycle is issued to both memories, then the
// read, multiply and accumulate stages drain and the sum loads the output register.
// Reset (synchronous, active low) restores tap_count to 101 and empties the history
// by zeroing a fill count. The block stalls only when a sum finishes while the
// output register still holds an untaken result.

module matched_filter_correlator #(
  parameter int MAX_TAPS = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mfc_pkg::in_item_t               in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mfc_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mfc_pkg::TAP_BITS-1:0]    cfg_data
);

  import mfc_pkg::*;

  // Address width of both memories, width of the fill count, and a width that
  // holds both the tap count register and MAX_TAPS.
  localparam int AW = $clog2(MAX_TAPS);
  localparam int FW = $clog2(MAX_TAPS + 1);
  localparam int TW = (FW > TAP_BITS) ? FW : TAP_BITS;
  // Template index widened so that MAX_TAPS itself fits for the range check.
  localparam int IW = ((AW > TIDX_BITS) ? AW : TIDX_BITS) + 1;

  st_t                   state_r, state_nxt;
  logic [TAP_BITS-1:0]   tap_count_r;
  logic [AW-1:0]         ptr_r, ptr_nxt;       // next history slot to write
  logic [FW-1:0]         fill_r, fill_nxt;     // samples since clear, saturating
  logic [OIDX_BITS-1:0]  cnt_r, cnt_nxt;       // output counter
  logic [OIDX_BITS-1:0]  idx_r, idx_nxt;       // index of the sum in flight
  logic [AW-1:0]         tj_r, tj_nxt;         // template address, counts down
  logic [AW-1:0]         hidx_r, hidx_nxt;     // history address, counts back in age
  logic [FW-1:0]         live_r, live_nxt;     // taps left that see real history
  logic                  first_r, first_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;
  logic                  load_out;

  logic [TW-1:0]         tc_ext;
  logic [TW-1:0]         taps;
  logic [TW-1:0]         taps_m1;
  logic [IW-1:0]         tidx_ext;
  logic                  tidx_ok;

  logic                  tmpl_we;
  logic                  hist_we;
  logic [SAMPLE_BITS-1:0] hist_wdata;
  logic [SAMPLE_BITS-1:0] tmpl_rdata;
  logic [SAMPLE_BITS-1:0] hist_rdata;

  mac_ctl_t                    mac_ctl;
  logic signed [CONV_BITS-1:0] mac_acc;
  logic                        mac_done;

  // Tap count in use: zero means one tap, anything above MAX_TAPS saturates.
  always_comb begin
    tc_ext   = TW'(tap_count_r);
    if (tc_ext == '0) begin
      taps = TW'(1);
    end else if (tc_ext > TW'(MAX_TAPS)) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = tc_ext;
    end
    taps_m1  = taps - TW'(1);
    tidx_ext = IW'(in_item.template_index);
    tidx_ok  = tidx_ext < IW'(MAX_TAPS);
  end

  // The template store and the history ring. The history is never cleared in
  // place: entries older than the fill count are masked to zero in the MAC.
  mfc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_BITS)
  ) u_tmpl_ram (
    .clk   (clk),
    .we    (tmpl_we),
    .waddr (tidx_ext[AW-1:0]),
    .wdata (in_item.sample),
    .raddr (tj_r),
    .rdata (tmpl_rdata)
  );

  mfc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_BITS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ptr_r),
    .wdata (hist_wdata),
    .raddr (hidx_r),
    .rdata (hist_rdata)
  );

  always_comb begin
    mac_ctl.vld   = (state_r == ST_RUN);
    mac_ctl.live  = (live_r != '0);
    mac_ctl.first = first_r;
    mac_ctl.last  = (tj_r == '0);
  end

  mfc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .tap_data  ($signed(tmpl_rdata)),
    .hist_data ($signed(hist_rdata)),
    .acc       (mac_acc),
    .done      (mac_done)
  );

  // Sequencer: next state, counters and memory writes.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    tj_nxt        = tj_r;
    hidx_nxt      = hidx_r;
    live_nxt      = live_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    tmpl_we       = 1'b0;
    hist_we       = 1'b0;
    hist_wdata    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_item.req_type) inside
            REQ_TMPL: begin
              tmpl_we = tidx_ok;
            end
            REQ_SIGNAL, REQ_FLUSH: begin
              // The new sample lands at the current slot; the sum then walks
              // back in age from that slot while the template walks down.
              hist_we    = 1'b1;
              hist_wdata = (in_item.req_type == REQ_SIGNAL) ? in_item.sample : '0;
              hidx_nxt   = ptr_r;
              ptr_nxt    = (ptr_r == AW'(MAX_TAPS - 1)) ? '0 : ptr_r + AW'(1);
              fill_nxt   = (fill_r == FW'(MAX_TAPS)) ? fill_r : fill_r + FW'(1);
              live_nxt   = fill_nxt;
              tj_nxt     = taps_m1[AW-1:0];
              first_nxt  = 1'b1;
              idx_nxt    = cnt_r;
              cnt_nxt    = cnt_r + OIDX_BITS'(1);
              state_nxt  = ST_RUN;
            end
            REQ_CLEAR: begin
              ptr_nxt  = '0;
              fill_nxt = '0;
              cnt_nxt  = '0;
            end
          endcase
        end
      end
      ST_RUN: begin
        first_nxt = 1'b0;
        live_nxt  = (live_r != '0) ? live_r - FW'(1) : live_r;
        hidx_nxt  = (hidx_r == '0) ? AW'(MAX_TAPS - 1) : hidx_r - AW'(1);
        tj_nxt    = tj_r - AW'(1);
        if (tj_r == '0) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          if (!out_valid_r || out_ready) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // The accumulator holds its sum until the output register frees up.
        if (out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_RESET;
      ptr_r       <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      live_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      live_r      <= live_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        tap_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    tj_r   <= tj_nxt;
    hidx_r <= hidx_nxt;
    if (load_out) begin
      out_item_r.conv_value <= mac_acc;
      out_item_r.out_index  <= idx_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
